### rtl/lrut_pkg.sv
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types and constants for the LRU hit tracker.
// ----------------------------------------------------------------------------
package lrut_pkg;

  localparam int IdW = 7;                  // expert identifier width
  localparam int NumExperts = 128;         // identifiers at or above this miss
  localparam int CapW = 8;                 // capacity register width
  localparam int CntW = 48;                // saturating counter width
  localparam int InDataW = 8;              // s_axis_tdata width
  localparam int OutDataW = 112;           // m_axis_tdata width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_UPDATE
  } state_e;

  // Per-transaction control broadcast to every cell of the stack.
  typedef struct packed {
    logic           match_en;   // capture compare results
    logic           update_en;  // perform the push-front shift
    logic [IdW-1:0] query;      // identifier of the current access
  } cell_ctrl_t;

endpackage

### rtl/lrut_cell.sv
// ----------------------------------------------------------------------------
// lrut_cell
// One slot of the recency stack: holds an identifier, compares it against
// the query and takes its left neighbor's entry during a push-front.
// ----------------------------------------------------------------------------
module lrut_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lrut_pkg::cell_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]         occ_i,
  input  logic [CNT_W-1:0]         limit_i,
  input  logic [lrut_pkg::IdW-1:0] left_i,
  output logic [lrut_pkg::IdW-1:0] entry_o,
  output logic                     match_o,
  output logic                     tail_o
);

  logic [lrut_pkg::IdW-1:0] entry_q, entry_d;
  logic                     match_q, tail_q;
  logic                     in_use;

  assign in_use = occ_i > CNT_W'(IDX);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.update_en) begin
      if (IDX == 0) begin
        entry_d = ctrl_i.query;
      end else if (limit_i >= CNT_W'(IDX)) begin
        entry_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      tail_q  <= 1'b0;
    end else if (ctrl_i.match_en) begin
      match_q <= in_use && (entry_q == ctrl_i.query);
      tail_q  <= occ_i == CNT_W'(IDX + 1);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign tail_o  = tail_q;

endmodule

### rtl/lru_cache_hit_tracker.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_tracker
// Fully associative LRU tracker over expert identifiers, built as a row of
// stack cells ordered most recent first.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one expert_id per transaction (tdata[6:0]). m_axis returns
//   one result per access: hit, evicted_valid, evicted_id, access_count and
//   hit_count. The cfg channel writes the capacity (0 disables caching); write
//   it only while no access is in flight.
// Timing:
//   An access is accepted only in the idle state and passes through compare,
//   resolve and update in that order; the update step writes the result into
//   the output register. No new access is taken until the current one has
//   left the update step, as the compare -> priority encode -> shift sequence
//   over the cell row handles one access at a time.
// Reset:
//   Stack empty, counters zero, capacity zero. No clearing pass is needed.
// Stall:
//   While the output register holds an untaken result, the update step
//   waits and the input side stays not ready; nothing is dropped.
// ----------------------------------------------------------------------------
module lru_cache_hit_tracker #(
  parameter int MAX_CAPACITY = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg: capacity
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lrut_pkg::CapW-1:0]       cfg_data_i,
  // tdata: expert_id[6:0], zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lrut_pkg::InDataW-1:0]    s_axis_tdata,
  // tdata: hit, evicted_valid, evicted_id[6:0], access_count[47:0],
  //        hit_count[47:0], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lrut_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int CNT_W = $clog2(MAX_CAPACITY + 1);
  localparam int CMP_W = (CNT_W > lrut_pkg::CapW) ? CNT_W : lrut_pkg::CapW;
  localparam int IW    = lrut_pkg::IdW;

  lrut_pkg::state_e state_q, state_d;

  logic [IW-1:0]              id_q;
  logic [lrut_pkg::CapW-1:0]  cap_q;
  logic [CNT_W-1:0]           occ_q;
  logic                       act_q, hit_q, evict_q, occ_inc_q;
  logic [IW-1:0]              victim_q;
  logic [CNT_W-1:0]           limit_q;
  logic [lrut_pkg::CntW-1:0]  acc_q, hitc_q, acc_d, hitc_d;
  logic                       out_valid_q;
  logic [lrut_pkg::OutDataW-1:0] out_data_q;

  logic                       in_go, upd_go, match_en, resolve_en;
  lrut_pkg::cell_ctrl_t       ctrl;

  logic [MAX_CAPACITY-1:0]    match_w, tail_w;
  logic [IW-1:0]              entry_w [MAX_CAPACITY];

  // ---- control ---------------------------------------------------------
  assign in_go = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrut_pkg::ST_IDLE:    if (in_go) state_d = lrut_pkg::ST_MATCH;
      lrut_pkg::ST_MATCH:   state_d = lrut_pkg::ST_RESOLVE;
      lrut_pkg::ST_RESOLVE: state_d = lrut_pkg::ST_UPDATE;
      lrut_pkg::ST_UPDATE:  if (upd_go) state_d = lrut_pkg::ST_IDLE;
      default:              state_d = lrut_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    match_en      = 1'b0;
    resolve_en    = 1'b0;
    upd_go        = 1'b0;
    case (state_q)
      lrut_pkg::ST_IDLE:    s_axis_tready = 1'b1;
      lrut_pkg::ST_MATCH:   match_en = 1'b1;
      lrut_pkg::ST_RESOLVE: resolve_en = 1'b1;
      lrut_pkg::ST_UPDATE:  upd_go = !out_valid_q || m_axis_tready;
      default:              s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrut_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      id_q <= s_axis_tdata[IW-1:0];
    end
  end

  // ---- cell row --------------------------------------------------------
  assign ctrl.match_en  = match_en;
  assign ctrl.update_en = upd_go && act_q;
  assign ctrl.query     = id_q;

  for (genvar k = 0; k < MAX_CAPACITY; k++) begin : g_cell
    logic [IW-1:0] left;
    if (k == 0) begin : g_head
      assign left = id_q;
    end else begin : g_body
      assign left = entry_w[k-1];
    end
    lrut_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .occ_i   (occ_q),
      .limit_i (limit_q),
      .left_i  (left),
      .entry_o (entry_w[k]),
      .match_o (match_w[k]),
      .tail_o  (tail_w[k])
    );
  end

  // ---- resolve: encode hit position and pick the LRU victim -------------
  logic [CNT_W-1:0] pos;
  logic [IW-1:0]    victim;
  logic [CMP_W-1:0] cap_eff;
  logic             act, match_any, at_cap;
  logic [CNT_W-1:0] limit;

  always_comb begin
    pos    = '0;
    victim = '0;
    for (int k = 0; k < MAX_CAPACITY; k++) begin
      pos    = pos | (match_w[k] ? CNT_W'(k) : '0);
      victim = victim | (tail_w[k] ? entry_w[k] : '0);
    end
  end

  assign cap_eff   = (CMP_W'(cap_q) > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY)
                                                            : CMP_W'(cap_q);
  assign act       = (cap_eff != '0) && (32'(id_q) < lrut_pkg::NumExperts);
  assign match_any = |match_w;
  assign at_cap    = (CMP_W'(occ_q) >= cap_eff) && (occ_q != '0);

  always_comb begin
    if (match_any) begin
      limit = pos;
    end else if (at_cap) begin
      limit = occ_q - CNT_W'(1);
    end else if (occ_q >= CNT_W'(MAX_CAPACITY - 1)) begin
      limit = CNT_W'(MAX_CAPACITY - 1);
    end else begin
      limit = occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      hit_q     <= 1'b0;
      evict_q   <= 1'b0;
      occ_inc_q <= 1'b0;
    end else if (resolve_en) begin
      act_q     <= act;
      hit_q     <= act && match_any;
      evict_q   <= act && !match_any && at_cap;
      occ_inc_q <= act && !match_any && !at_cap && (occ_q < CNT_W'(MAX_CAPACITY));
    end
  end

  always_ff @(posedge clk_i) begin
    if (resolve_en) begin
      victim_q <= victim;
      limit_q  <= limit;
    end
  end

  // ---- update: occupancy, counters, output register --------------------
  assign acc_d  = (acc_q == '1) ? acc_q : acc_q + lrut_pkg::CntW'(1);
  assign hitc_d = (hit_q && (hitc_q != '1)) ? hitc_q + lrut_pkg::CntW'(1) : hitc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      acc_q  <= '0;
      hitc_q <= '0;
    end else if (upd_go) begin
      if (occ_inc_q) begin
        occ_q <= occ_q + CNT_W'(1);
      end
      acc_q  <= acc_d;
      hitc_q <= hitc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      out_data_q <= {7'd0, hitc_d, acc_d, (evict_q ? victim_q : IW'(0)), evict_q, hit_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---- assertions ------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(MAX_CAPACITY))
    else $error("occupancy above maximum capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lrut_pkg::ST_RESOLVE |-> $onehot0(match_w))
    else $error("identifier resident in more than one cell");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lrut_pkg::ST_UPDATE |-> !(hit_q && evict_q))
    else $error("hit and eviction in the same access");

  a_cnt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hitc_q <= acc_q)
    else $error("hit count exceeds access count");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_go |=> $stable(occ_q))
    else $error("occupancy changed outside an update");

endmodule
